/* src/inverse_bilinear_quad_map_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the inverse bilinear quad map
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INVERSE_BILINEAR_QUAD_MAP_TOP_MACROS_SVH
`define INVERSE_BILINEAR_QUAD_MAP_TOP_MACROS_SVH

// Same-cycle implication.
`define IBQM_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication.
`define IBQM_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

/* src/ibqm_pkg.sv */
// ----------------------------------------------------------------------------
// ibqm_pkg
// Widths, payload types and register codes for the inverse bilinear quad map.
// ----------------------------------------------------------------------------
package ibqm_pkg;

    localparam int CW   = 24;              // coordinate width
    localparam int UVW  = 16;              // u, v fraction width
    localparam int DW   = CW + 2;          // edge vectors e, f, g, h
    localparam int PRW  = 2 * DW;          // cross product terms
    localparam int KW   = 54;              // k0, k1, k2
    localparam int HW   = KW / 2;          // half of a k magnitude
    localparam int SQW  = 108;             // discriminant
    localparam int RTW  = SQW / 2;         // square root bits
    localparam int VW   = 56;              // signed root numerator, denominator
    localparam int MW   = 53;              // positive root magnitude
    localparam int PW   = 84;              // u numerator, denominator
    localparam int NREG = 8;
    localparam int AW   = 5;               // APB address bits
    localparam int LAT  = 8 + RTW + 7 + UVW + 1;

    typedef enum logic [2:0] {
        REG_C0X, REG_C0Y, REG_C1X, REG_C1Y, REG_C2X, REG_C2Y, REG_C3X, REG_C3Y
    } reg_idx_t;

    localparam logic signed [CW-1:0] CFG_RST [NREG] = '{
        CW'(0), CW'(0), CW'(256), CW'(0), CW'(256), CW'(256), CW'(0), CW'(256)
    };

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
    } in_t;

    typedef struct packed {
        logic [UVW-1:0] tex_u;
        logic [UVW-1:0] tex_v;
        logic           inside_res;
    } out_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
    } vec_t;

    typedef struct packed {
        vec_t e;
        vec_t f;
        vec_t g;
        vec_t h;
    } geo_t;

    typedef struct packed {
        geo_t                 geo;
        logic signed [KW-1:0] k0;
        logic signed [KW-1:0] k1;
        logic signed [KW-1:0] k2;
        logic                 disc_neg;
    } sq_pl_t;

    typedef struct packed {
        logic signed [VW-1:0] vn;
        logic signed [VW-1:0] vd;
        logic                 first;
        logic                 en;
    } root_in_t;

    typedef struct packed {
        logic           ok;
        logic [UVW-1:0] u;
        logic [UVW-1:0] v;
    } res_t;

endpackage

/* src/ibqm_isqrt.sv */
// ----------------------------------------------------------------------------
// ibqm_isqrt
// Pipelined floor square root, one result bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module ibqm_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [ibqm_pkg::SQW-1:0]   in_x,
    input  ibqm_pkg::sq_pl_t           in_pl,
    output logic                       out_vld,
    output logic [ibqm_pkg::RTW-1:0]   out_root,
    output ibqm_pkg::sq_pl_t           out_pl
);

    logic                     vld_reg [0:ibqm_pkg::RTW];
    logic [ibqm_pkg::SQW-1:0] x_reg   [0:ibqm_pkg::RTW];
    logic [ibqm_pkg::SQW-1:0] r_reg   [0:ibqm_pkg::RTW];
    ibqm_pkg::sq_pl_t         pl_reg  [0:ibqm_pkg::RTW];

    always_comb
    begin
        vld_reg[0] = in_vld;
        x_reg[0]   = in_x;
        r_reg[0]   = '0;
        pl_reg[0]  = in_pl;
    end

    for (genvar j = 0; j < ibqm_pkg::RTW; j++)
    begin : g_stage
        localparam logic [ibqm_pkg::SQW-1:0] ONE =
            ibqm_pkg::SQW'(1) << (2 * (ibqm_pkg::RTW - 1 - j));
        logic [ibqm_pkg::SQW-1:0] t;
        logic [ibqm_pkg::SQW-1:0] x_next;
        logic [ibqm_pkg::SQW-1:0] r_next;

        always_comb
        begin
            t = r_reg[j] + ONE;
            if (x_reg[j] >= t)
            begin
                x_next = x_reg[j] - t;
                r_next = (r_reg[j] >> 1) + ONE;
            end
            else
            begin
                x_next = x_reg[j];
                r_next = r_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            x_reg[j+1]  <= x_next;
            r_reg[j+1]  <= r_next;
            pl_reg[j+1] <= pl_reg[j];
        end
    end

    assign out_vld  = vld_reg[ibqm_pkg::RTW];
    assign out_root = r_reg[ibqm_pkg::RTW][ibqm_pkg::RTW-1:0];
    assign out_pl   = pl_reg[ibqm_pkg::RTW];

endmodule

/* src/ibqm_root.sv */
// ----------------------------------------------------------------------------
// ibqm_root
// Check one candidate v = vn/vd, solve u on the chosen axis, quantize both.
// ----------------------------------------------------------------------------
module ibqm_root (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  ibqm_pkg::root_in_t   cand,
    input  ibqm_pkg::geo_t       geo,
    output logic                 out_vld,
    output ibqm_pkg::res_t       res
);

    localparam int LPW = ibqm_pkg::HW + 1 + ibqm_pkg::DW;
    localparam int HPW = ibqm_pkg::MW - ibqm_pkg::HW + 1 + ibqm_pkg::DW;

    logic [6:1] vld_reg;

    // stage A: make the denominator positive
    logic signed [ibqm_pkg::VW-1:0] vn1_reg, vd1_reg;
    logic                           z1_reg, en1_reg, first1_reg;
    ibqm_pkg::geo_t                 geo1_reg;

    // stage B: v range check
    logic [ibqm_pkg::MW-1:0] vn2_reg, vd2_reg;
    logic                    ok2_reg, first2_reg;
    ibqm_pkg::geo_t          geo2_reg;

    // stage C: partial products, [axis][term]
    logic signed [ibqm_pkg::DW-1:0] cf [2][4];
    logic signed [LPW-1:0]          plo_reg [2][4];
    logic signed [HPW-1:0]          phi_reg [2][4];
    logic                           ok3_reg, first3_reg;
    logic [ibqm_pkg::MW-1:0]        vn3_reg, vd3_reg;

    // stage D: full products
    logic signed [ibqm_pkg::PW-1:0] prod_reg [2][4];
    logic                           ok4_reg, first4_reg;
    logic [ibqm_pkg::MW-1:0]        vn4_reg, vd4_reg;

    // stage E: numerators and denominators of u per axis
    logic signed [ibqm_pkg::PW-1:0] ud5_reg [2];
    logic signed [ibqm_pkg::PW-1:0] un5_reg [2];
    logic                           ok5_reg, first5_reg;
    logic [ibqm_pkg::MW-1:0]        vn5_reg, vd5_reg;

    // stage F: axis choice
    logic signed [ibqm_pkg::PW-1:0] ud6_reg, un6_reg;
    logic                           ok6_reg;
    logic [ibqm_pkg::MW-1:0]        vn6_reg, vd6_reg;
    logic                           sel;
    logic signed [ibqm_pkg::PW-1:0] uds, uns;

    // quantizer stages, index 0 is stage G
    logic                    ok_q  [0:ibqm_pkg::UVW];
    logic                    vq_vld[0:ibqm_pkg::UVW];
    logic [ibqm_pkg::PW-1:0] un_q  [0:ibqm_pkg::UVW];
    logic [ibqm_pkg::PW-1:0] ud_q  [0:ibqm_pkg::UVW];
    logic [ibqm_pkg::MW-1:0] vn_q  [0:ibqm_pkg::UVW];
    logic [ibqm_pkg::MW-1:0] vd_q  [0:ibqm_pkg::UVW];
    logic [ibqm_pkg::UVW-1:0] qu  [0:ibqm_pkg::UVW];
    logic [ibqm_pkg::UVW-1:0] qv  [0:ibqm_pkg::UVW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:1], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (cand.vd < 0)
        begin
            vn1_reg <= -cand.vn;
            vd1_reg <= -cand.vd;
        end
        else
        begin
            vn1_reg <= cand.vn;
            vd1_reg <= cand.vd;
        end
        z1_reg     <= (cand.vd == '0);
        en1_reg    <= cand.en;
        first1_reg <= cand.first;
        geo1_reg   <= geo;
    end

    always_ff @(posedge clk)
    begin
        ok2_reg    <= en1_reg && !z1_reg && (vn1_reg > 0) && (vn1_reg < vd1_reg);
        vn2_reg    <= vn1_reg[ibqm_pkg::MW-1:0];
        vd2_reg    <= vd1_reg[ibqm_pkg::MW-1:0];
        first2_reg <= first1_reg;
        geo2_reg   <= geo1_reg;
    end

    // terms: vd*e, vn*g, vd*h, vn*f
    always_comb
    begin
        cf[0][0] = geo2_reg.e.x;
        cf[0][1] = geo2_reg.g.x;
        cf[0][2] = geo2_reg.h.x;
        cf[0][3] = geo2_reg.f.x;
        cf[1][0] = geo2_reg.e.y;
        cf[1][1] = geo2_reg.g.y;
        cf[1][2] = geo2_reg.h.y;
        cf[1][3] = geo2_reg.f.y;
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        for (genvar k = 0; k < 4; k++)
        begin : g_term
            logic [ibqm_pkg::MW-1:0] m;
            assign m = (k % 2 == 0) ? vd2_reg : vn2_reg;

            always_ff @(posedge clk)
            begin
                plo_reg[a][k] <= $signed({1'b0, m[ibqm_pkg::HW-1:0]}) * cf[a][k];
                phi_reg[a][k] <= $signed({1'b0, m[ibqm_pkg::MW-1:ibqm_pkg::HW]}) * cf[a][k];
                prod_reg[a][k] <= (ibqm_pkg::PW'(phi_reg[a][k]) <<< ibqm_pkg::HW)
                                  + ibqm_pkg::PW'(plo_reg[a][k]);
            end
        end

        always_ff @(posedge clk)
        begin
            ud5_reg[a] <= prod_reg[a][0] + prod_reg[a][1];
            un5_reg[a] <= prod_reg[a][2] - prod_reg[a][3];
        end
    end

    always_ff @(posedge clk)
    begin
        ok3_reg    <= ok2_reg;
        first3_reg <= first2_reg;
        vn3_reg    <= vn2_reg;
        vd3_reg    <= vd2_reg;
        ok4_reg    <= ok3_reg;
        first4_reg <= first3_reg;
        vn4_reg    <= vn3_reg;
        vd4_reg    <= vd3_reg;
        ok5_reg    <= ok4_reg;
        first5_reg <= first4_reg;
        vn5_reg    <= vn4_reg;
        vd5_reg    <= vd4_reg;
    end

    // preferred axis first, fall back to the other on a zero divisor
    always_comb
    begin
        sel = (ud5_reg[first5_reg] != '0) ? first5_reg : !first5_reg;
        uds = ud5_reg[sel];
        uns = un5_reg[sel];
    end

    always_ff @(posedge clk)
    begin
        ok6_reg <= ok5_reg && (uds != '0);
        if (uds < 0)
        begin
            ud6_reg <= -uds;
            un6_reg <= -uns;
        end
        else
        begin
            ud6_reg <= uds;
            un6_reg <= uns;
        end
        vn6_reg <= vn5_reg;
        vd6_reg <= vd5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_vld[0] <= 1'b0;
        else
            vq_vld[0] <= vld_reg[6];
    end

    always_ff @(posedge clk)
    begin
        ok_q[0] <= ok6_reg && (un6_reg > 0) && (un6_reg < ud6_reg);
        un_q[0] <= un6_reg;
        ud_q[0] <= ud6_reg;
        vn_q[0] <= vn6_reg;
        vd_q[0] <= vd6_reg;
        qu[0]   <= '0;
        qv[0]   <= '0;
    end

    for (genvar i = 0; i < ibqm_pkg::UVW; i++)
    begin : g_quant
        logic [ibqm_pkg::PW:0] nu;
        logic [ibqm_pkg::MW:0] nv;
        logic                  bu, bv;

        always_comb
        begin
            nu = {un_q[i], 1'b0};
            nv = {vn_q[i], 1'b0};
            bu = (nu >= {1'b0, ud_q[i]});
            bv = (nv >= {1'b0, vd_q[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_vld[i+1] <= 1'b0;
            else
                vq_vld[i+1] <= vq_vld[i];
        end

        always_ff @(posedge clk)
        begin
            un_q[i+1] <= bu ? ibqm_pkg::PW'(nu - {1'b0, ud_q[i]}) : ibqm_pkg::PW'(nu);
            vn_q[i+1] <= bv ? ibqm_pkg::MW'(nv - {1'b0, vd_q[i]}) : ibqm_pkg::MW'(nv);
            ud_q[i+1] <= ud_q[i];
            vd_q[i+1] <= vd_q[i];
            ok_q[i+1] <= ok_q[i];
            qu[i+1]   <= {qu[i][ibqm_pkg::UVW-2:0], bu};
            qv[i+1]   <= {qv[i][ibqm_pkg::UVW-2:0], bv};
        end
    end

    assign out_vld = vq_vld[ibqm_pkg::UVW];
    assign res.ok  = ok_q[ibqm_pkg::UVW];
    assign res.u   = qu[ibqm_pkg::UVW];
    assign res.v   = qv[ibqm_pkg::UVW];

endmodule

/* src/inverse_bilinear_quad_map_top.sv */
// ----------------------------------------------------------------------------
// inverse_bilinear_quad_map_top
// Map a query point to (u, v) inside a configured quad by inverting its
// bilinear parameterization.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+-----------------------------
//  point in  | start high, busy low            | point (point_x, point_y)
//  result    | done high for one cycle         | result (tex_u, tex_v, inside_res)
//  config    | psel, penable, pwrite (APB)     | paddr, pwdata, prdata
//
//  One item enters per cycle; busy never rises. Each item passes through
//  eight front stages (edge vectors, cross products, k terms, squaring
//  partials, discriminant, root candidates), one stage per bit of the
//  54-bit square root, seven stages of root check and u solve, sixteen
//  quantizer stages and the output register.
//  rst_n clears the valid pipeline and loads the unit-square corners.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "inverse_bilinear_quad_map_top_macros.svh"

module inverse_bilinear_quad_map_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  ibqm_pkg::in_t            point,
    output logic                     done,
    output ibqm_pkg::out_t           result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ibqm_pkg::AW-1:0]  paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ibqm_pkg::CW-1:0] cfg_reg [ibqm_pkg::NREG];
    ibqm_pkg::reg_idx_t             widx;
    logic                           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign widx   = ibqm_pkg::reg_idx_t'(paddr[ibqm_pkg::AW-1:2]);
    assign prdata = 32'(cfg_reg[widx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= ibqm_pkg::CFG_RST;
        else if (wr)
            cfg_reg[widx] <= pwdata[ibqm_pkg::CW-1:0];
    end

    // ------------------------------------------------------------------
    // Front pipeline: valid bits
    // ------------------------------------------------------------------
    logic acc;
    logic [7:1] vld_reg;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[6:1], acc};
    end

    // ------------------------------------------------------------------
    // Stage 1: edge vectors e = c1-c0, f = c3-c0, g = c0-c1+c2-c3, h = p-c0
    // ------------------------------------------------------------------
    ibqm_pkg::geo_t geo1_reg, geo2_reg, geo3_reg, geo4_reg, geo5_reg, geo6_reg, geo7_reg;

    always_ff @(posedge clk)
    begin
        geo1_reg.e.x <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C1X])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0X]);
        geo1_reg.e.y <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C1Y])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0Y]);
        geo1_reg.f.x <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C3X])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0X]);
        geo1_reg.f.y <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C3Y])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0Y]);
        geo1_reg.g.x <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0X])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C1X])
                        + ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C2X])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C3X]);
        geo1_reg.g.y <= ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0Y])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C1Y])
                        + ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C2Y])
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C3Y]);
        geo1_reg.h.x <= ibqm_pkg::DW'(point.point_x)
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0X]);
        geo1_reg.h.y <= ibqm_pkg::DW'(point.point_y)
                        - ibqm_pkg::DW'(cfg_reg[ibqm_pkg::REG_C0Y]);
    end

    // ------------------------------------------------------------------
    // Stage 2: the eight cross product terms
    // ------------------------------------------------------------------
    logic signed [ibqm_pkg::PRW-1:0] p2_reg [8];

    always_ff @(posedge clk)
    begin
        p2_reg[0] <= geo1_reg.g.x * geo1_reg.f.y;
        p2_reg[1] <= geo1_reg.g.y * geo1_reg.f.x;
        p2_reg[2] <= geo1_reg.e.x * geo1_reg.f.y;
        p2_reg[3] <= geo1_reg.e.y * geo1_reg.f.x;
        p2_reg[4] <= geo1_reg.h.x * geo1_reg.g.y;
        p2_reg[5] <= geo1_reg.h.y * geo1_reg.g.x;
        p2_reg[6] <= geo1_reg.h.x * geo1_reg.e.y;
        p2_reg[7] <= geo1_reg.h.y * geo1_reg.e.x;
        geo2_reg  <= geo1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: quadratic coefficients k2 v^2 + k1 v + k0
    // ------------------------------------------------------------------
    logic signed [ibqm_pkg::KW-1:0] k0_reg [3:7];
    logic signed [ibqm_pkg::KW-1:0] k1_reg [3:7];
    logic signed [ibqm_pkg::KW-1:0] k2_reg [3:7];

    always_ff @(posedge clk)
    begin
        k2_reg[3] <= ibqm_pkg::KW'(p2_reg[0]) - ibqm_pkg::KW'(p2_reg[1]);
        k1_reg[3] <= ibqm_pkg::KW'(p2_reg[2]) - ibqm_pkg::KW'(p2_reg[3])
                     + ibqm_pkg::KW'(p2_reg[4]) - ibqm_pkg::KW'(p2_reg[5]);
        k0_reg[3] <= ibqm_pkg::KW'(p2_reg[6]) - ibqm_pkg::KW'(p2_reg[7]);
        geo3_reg  <= geo2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes for k1^2 and k0*k2
    // ------------------------------------------------------------------
    logic [ibqm_pkg::KW-1:0] m0_reg, m1_reg, m2_reg;
    logic                    sgn_reg [4:6];

    always_ff @(posedge clk)
    begin
        m0_reg     <= k0_reg[3][ibqm_pkg::KW-1] ? ibqm_pkg::KW'(-k0_reg[3])
                                                : ibqm_pkg::KW'(k0_reg[3]);
        m1_reg     <= k1_reg[3][ibqm_pkg::KW-1] ? ibqm_pkg::KW'(-k1_reg[3])
                                                : ibqm_pkg::KW'(k1_reg[3]);
        m2_reg     <= k2_reg[3][ibqm_pkg::KW-1] ? ibqm_pkg::KW'(-k2_reg[3])
                                                : ibqm_pkg::KW'(k2_reg[3]);
        sgn_reg[4] <= k0_reg[3][ibqm_pkg::KW-1] ^ k2_reg[3][ibqm_pkg::KW-1];
    end

    // ------------------------------------------------------------------
    // Stage 5: half-width partial products
    // ------------------------------------------------------------------
    logic [2*ibqm_pkg::HW-1:0] sq_hh_reg, sq_hl_reg, sq_ll_reg;
    logic [2*ibqm_pkg::HW-1:0] pr_hh_reg, pr_hl_reg, pr_lh_reg, pr_ll_reg;

    always_ff @(posedge clk)
    begin
        sq_hh_reg <= m1_reg[ibqm_pkg::KW-1:ibqm_pkg::HW] * m1_reg[ibqm_pkg::KW-1:ibqm_pkg::HW];
        sq_hl_reg <= m1_reg[ibqm_pkg::KW-1:ibqm_pkg::HW] * m1_reg[ibqm_pkg::HW-1:0];
        sq_ll_reg <= m1_reg[ibqm_pkg::HW-1:0] * m1_reg[ibqm_pkg::HW-1:0];
        pr_hh_reg <= m0_reg[ibqm_pkg::KW-1:ibqm_pkg::HW] * m2_reg[ibqm_pkg::KW-1:ibqm_pkg::HW];
        pr_hl_reg <= m0_reg[ibqm_pkg::KW-1:ibqm_pkg::HW] * m2_reg[ibqm_pkg::HW-1:0];
        pr_lh_reg <= m0_reg[ibqm_pkg::HW-1:0] * m2_reg[ibqm_pkg::KW-1:ibqm_pkg::HW];
        pr_ll_reg <= m0_reg[ibqm_pkg::HW-1:0] * m2_reg[ibqm_pkg::HW-1:0];
        sgn_reg[5] <= sgn_reg[4];
    end

    // ------------------------------------------------------------------
    // Stage 6: assemble k1^2 and |k0*k2|
    // ------------------------------------------------------------------
    logic [ibqm_pkg::SQW-1:0] sq_reg, pr_reg;

    always_ff @(posedge clk)
    begin
        sq_reg <= (ibqm_pkg::SQW'(sq_hh_reg) << (2 * ibqm_pkg::HW))
                  + (ibqm_pkg::SQW'(sq_hl_reg) << (ibqm_pkg::HW + 1))
                  + ibqm_pkg::SQW'(sq_ll_reg);
        pr_reg <= (ibqm_pkg::SQW'(pr_hh_reg) << (2 * ibqm_pkg::HW))
                  + ((ibqm_pkg::SQW'(pr_hl_reg) + ibqm_pkg::SQW'(pr_lh_reg)) << ibqm_pkg::HW)
                  + ibqm_pkg::SQW'(pr_ll_reg);
        sgn_reg[6] <= sgn_reg[5];
    end

    // ------------------------------------------------------------------
    // Stage 7: discriminant k1^2 - 4 k0 k2, feed the square root
    // ------------------------------------------------------------------
    logic [ibqm_pkg::SQW-1:0] disc;
    logic [ibqm_pkg::SQW-1:0] sx_reg;
    logic                     dneg7_reg;

    assign disc = sgn_reg[6] ? sq_reg + (pr_reg << 2) : sq_reg - (pr_reg << 2);

    always_ff @(posedge clk)
    begin
        dneg7_reg <= disc[ibqm_pkg::SQW-1];
        sx_reg    <= disc[ibqm_pkg::SQW-1] ? '0 : disc;
    end

    // carry geometry and k terms alongside stages 4..7
    always_ff @(posedge clk)
    begin
        geo4_reg <= geo3_reg;
        geo5_reg <= geo4_reg;
        geo6_reg <= geo5_reg;
        geo7_reg <= geo6_reg;
        for (int s = 4; s <= 7; s++)
        begin
            k0_reg[s] <= k0_reg[s-1];
            k1_reg[s] <= k1_reg[s-1];
            k2_reg[s] <= k2_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Square root, one bit per stage
    // ------------------------------------------------------------------
    ibqm_pkg::sq_pl_t          sq_in_pl, sq_out_pl;
    logic                      sq_out_vld;
    logic [ibqm_pkg::RTW-1:0]  w_root;

    always_comb
    begin
        sq_in_pl.geo      = geo7_reg;
        sq_in_pl.k0       = k0_reg[7];
        sq_in_pl.k1       = k1_reg[7];
        sq_in_pl.k2       = k2_reg[7];
        sq_in_pl.disc_neg = dneg7_reg;
    end

    ibqm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[7]),
        .in_x     (sx_reg),
        .in_pl    (sq_in_pl),
        .out_vld  (sq_out_vld),
        .out_root (w_root),
        .out_pl   (sq_out_pl)
    );

    // ------------------------------------------------------------------
    // Stage 8: root candidates. Candidate A is the linear root or the
    // minus root; candidate B is the plus root and only used after A fails.
    // ------------------------------------------------------------------
    logic signed [ibqm_pkg::VW-1:0] wv, k0v, k1v, k2v;
    logic                           quad;
    ibqm_pkg::root_in_t             ca_reg, cb_reg;
    ibqm_pkg::geo_t                 geo8_reg;
    logic                           vld8_reg;

    always_comb
    begin
        wv   = ibqm_pkg::VW'(w_root);
        k0v  = ibqm_pkg::VW'(sq_out_pl.k0);
        k1v  = ibqm_pkg::VW'(sq_out_pl.k1);
        k2v  = ibqm_pkg::VW'(sq_out_pl.k2);
        quad = (sq_out_pl.k2 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld8_reg <= 1'b0;
        else
            vld8_reg <= sq_out_vld;
    end

    always_ff @(posedge clk)
    begin
        if (quad)
        begin
            ca_reg.vn    <= -k1v - wv;
            ca_reg.vd    <= k2v <<< 1;
            ca_reg.first <= 1'b1;
            ca_reg.en    <= !sq_out_pl.disc_neg;
        end
        else
        begin
            ca_reg.vn    <= -k0v;
            ca_reg.vd    <= k1v;
            ca_reg.first <= 1'b0;
            ca_reg.en    <= (sq_out_pl.k1 != '0);
        end
        cb_reg.vn    <= -k1v + wv;
        cb_reg.vd    <= k2v <<< 1;
        cb_reg.first <= 1'b1;
        cb_reg.en    <= quad && !sq_out_pl.disc_neg;
        geo8_reg     <= sq_out_pl.geo;
    end

    // ------------------------------------------------------------------
    // Both candidates checked in parallel
    // ------------------------------------------------------------------
    ibqm_pkg::res_t res_a, res_b;
    logic           vld_a, vld_b;

    ibqm_root u_root_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vld8_reg),
        .cand    (ca_reg),
        .geo     (geo8_reg),
        .out_vld (vld_a),
        .res     (res_a)
    );

    ibqm_root u_root_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vld8_reg),
        .cand    (cb_reg),
        .geo     (geo8_reg),
        .out_vld (vld_b),
        .res     (res_b)
    );

    // ------------------------------------------------------------------
    // Output register: prefer A, then B, else drop to outside
    // ------------------------------------------------------------------
    logic           done_reg;
    ibqm_pkg::out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_a;
    end

    always_ff @(posedge clk)
    begin
        if (res_a.ok)
        begin
            result_reg.tex_u      <= res_a.u;
            result_reg.tex_v      <= res_a.v;
            result_reg.inside_res <= 1'b1;
        end
        else if (res_b.ok)
        begin
            result_reg.tex_u      <= res_b.u;
            result_reg.tex_v      <= res_b.v;
            result_reg.inside_res <= 1'b1;
        end
        else
        begin
            result_reg.tex_u      <= '0;
            result_reg.tex_v      <= '0;
            result_reg.inside_res <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IBQM_ASSERT_IMP(a_latency, done, $past(start && !busy, ibqm_pkg::LAT), "result without item")
    `IBQM_ASSERT_IMP(a_lanes, vld_a || vld_b, vld_a && vld_b, "root lanes out of step")
    `IBQM_ASSERT_IMP(a_outside_zero, done && !result.inside_res,
        result.tex_u == '0 && result.tex_v == '0, "outside result not zero")
    `IBQM_ASSERT_NXT(a_enter, start && !busy, vld_reg[1], "item not entered")

endmodule

/* dv/ibqm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibqm_checker
// Watches the point and result channels and the register writes, predicts
// each result of the inverse bilinear quad map and compares in order.
// ----------------------------------------------------------------------------
module ibqm_checker
    import ibqm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  in_t               point,
    input  logic              done,
    input  out_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AW-1:0]     paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    logic signed [CW-1:0] corner [NREG];
    out_t                 uv_queue [$];

    localparam longint LIMV = 64'sd1 << 30;

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic logic signed [127:0] mag_abs(logic signed [127:0] a);
        return a < 0 ? -a : a;
    endfunction

    // floor(n/d * 2^UVW), n and d positive with n < d
    function automatic logic [UVW-1:0] quantize(logic signed [127:0] n,
                                               logic signed [127:0] d);
        logic [UVW-1:0] q;
        q = '0;
        for (int i = 0; i < UVW; i++)
        begin
            n = n <<< 1;
            q = q << 1;
            if (n >= d)
            begin
                n = n - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic solve_root(logic signed [127:0] vn, longint vdi,
                                        longint e [2], longint f [2],
                                        longint g [2], longint h [2], int first,
                                        output logic [UVW-1:0] tu,
                                        output logic [UVW-1:0] tv);
        logic signed [127:0] vd, un, ud;
        int ax;
        vd = vdi;
        tu = '0;
        tv = '0;
        ud = 0;
        ax = first;
        if (vd == 0)
            return 1'b0;
        if (vd < 0)
        begin
            vd = -vd;
            vn = -vn;
        end
        if (!(vn > 0 && vn < vd))
            return 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            ax = (k == 0) ? first : 1 - first;
            ud = vd * e[ax] + vn * g[ax];
            if (ud != 0)
                break;
        end
        if (ud == 0)
            return 1'b0;
        un = vd * h[ax] - vn * f[ax];
        if (ud < 0)
        begin
            ud = -ud;
            un = -un;
        end
        if (!(un > 0 && un < ud))
            return 1'b0;
        tu = quantize(un, ud);
        tv = quantize(vn, vd);
        return 1'b1;
    endfunction

    function automatic out_t predict_uv(in_t p);
        longint raw [8];
        longint e [2], f [2], g [2], h [2];
        longint c [NREG];
        longint k0, k1, k2;
        logic signed [127:0] disc, w, nk1;
        logic [UVW-1:0] tu, tv;
        logic ok, fits;
        int s;
        out_t r;
        for (int i = 0; i < NREG; i++)
            c[i] = corner[i];
        raw[0] = c[2] - c[0];
        raw[1] = c[3] - c[1];
        raw[2] = c[6] - c[0];
        raw[3] = c[7] - c[1];
        raw[4] = c[0] - c[2] + c[4] - c[6];
        raw[5] = c[1] - c[3] + c[5] - c[7];
        raw[6] = longint'(p.point_x) - c[0];
        raw[7] = longint'(p.point_y) - c[1];
        s = 0;
        fits = 1'b0;
        while (!fits)
        begin
            fits = 1'b1;
            for (int i = 0; i < 8; i++)
                if (floor_shr(raw[i], s) < -LIMV || floor_shr(raw[i], s) > LIMV - 1)
                    fits = 1'b0;
            if (!fits)
                s++;
        end
        for (int i = 0; i < 2; i++)
        begin
            e[i] = floor_shr(raw[i], s);
            f[i] = floor_shr(raw[2 + i], s);
            g[i] = floor_shr(raw[4 + i], s);
            h[i] = floor_shr(raw[6 + i], s);
        end
        k2 = g[0] * f[1] - g[1] * f[0];
        k1 = (e[0] * f[1] - e[1] * f[0]) + (h[0] * g[1] - h[1] * g[0]);
        k0 = h[0] * e[1] - h[1] * e[0];
        ok = 1'b0;
        tu = '0;
        tv = '0;
        if (k2 == 0)
        begin
            if (k1 != 0)
                ok = solve_root(-(128'(signed'(k0))), k1, e, f, g, h, 0, tu, tv);
        end
        else
        begin
            disc = 128'(signed'(k1)) * k1 - 4 * (128'(signed'(k0)) * k2);
            if (disc >= 0)
            begin
                // floor square root, bit by bit
                w = 0;
                for (int b = 62; b >= 0; b--)
                    if ((w | (128'sd1 << b)) * (w | (128'sd1 << b)) <= disc)
                        w = w | (128'sd1 << b);
                nk1 = -(128'(signed'(k1)));
                ok = solve_root(nk1 - w, 2 * k2, e, f, g, h, 1, tu, tv);
                if (!ok)
                    ok = solve_root(nk1 + w, 2 * k2, e, f, g, h, 1, tu, tv);
            end
        end
        r.tex_u = ok ? tu : '0;
        r.tex_v = ok ? tv : '0;
        r.inside_res = ok;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ibqm_checker: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = uv_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                corner[i] <= CFG_RST[i];
            uv_queue.delete();
            fail_count = 0;
        end
        else
        begin
            // register writes land at this edge; items taken now see the old corners
            if (start && !busy)
                uv_queue.push_back(predict_uv(point));
            if (done)
            begin
                if (uv_queue.size() == 0)
                    report_mismatch("unexpected result, count", 1, 0);
                else
                begin
                    want = uv_queue.pop_front();
                    if (result.tex_u !== want.tex_u)
                        report_mismatch("tex_u", result.tex_u, want.tex_u);
                    if (result.tex_v !== want.tex_v)
                        report_mismatch("tex_v", result.tex_v, want.tex_v);
                    if (result.inside_res !== want.inside_res)
                        report_mismatch("inside_res", result.inside_res, want.inside_res);
                end
            end
            if (psel && penable && pwrite && pready && (paddr >> 2) < NREG)
                corner[paddr >> 2] <= pwdata[CW-1:0];
        end
    end

endmodule

/* dv/tb_inverse_bilinear_quad_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverse_bilinear_quad_map_top
// Drives query points through the inverse bilinear quad map for a series of
// quad shapes written over APB; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_inverse_bilinear_quad_map_top;
    import ibqm_pkg::*;

    localparam int N_RANDOM = 800;
    localparam int CYCLE_LIMIT = 400000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    in_t              point = '0;
    logic             done;
    out_t             result;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AW-1:0]    paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    logic signed [CW-1:0] quad [NREG];

    always #4 clk = ~clk;

    inverse_bilinear_quad_map_top DUT (
        .clk, .rst_n, .start, .busy, .point, .done, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ibqm_checker u_checker (
        .clk, .rst_n, .start, .busy, .point, .done, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending
    );

    // Watchdog: end the run if something hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_inverse_bilinear_quad_map_top: done, errors");
            $finish;
        end
    end

    // Write one corner register: setup cycle, then access cycle.
    task automatic write_corner(reg_idx_t idx, logic signed [CW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(4 * int'(idx));
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Load a whole quad; only called when the pipeline is empty.
    task automatic load_quad();
        for (int i = 0; i < NREG; i++)
            write_corner(reg_idx_t'(i), quad[i]);
    endtask

    // Hand one point to the block; hold start until it is taken.
    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        start <= 1'b1;
        point <= '{point_x: x, point_y: y};
        do @(posedge clk); while (busy);
    endtask

    // Drop start, then idle a random gap; a zero gap keeps start high.
    task automatic idle_gap(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending != 0 && guard < 20 * LAT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LAT + 4) @(posedge clk);
    endtask

    // Random point near the quad so most land inside or on the rim.
    task automatic random_point(int span, output logic signed [CW-1:0] x,
                                output logic signed [CW-1:0] y);
        int lo_x, lo_y;
        if ($urandom_range(0, 9) == 0)
        begin
            x = CW'($urandom);
            y = CW'($urandom);
        end
        else
        begin
            lo_x = quad[REG_C0X] - span / 4;
            lo_y = quad[REG_C0Y] - span / 4;
            x = CW'(lo_x + int'($urandom_range(0, span + span / 2)));
            y = CW'(lo_y + int'($urandom_range(0, span + span / 2)));
        end
    endtask

    // Pick a random convex-ish, skewed or degenerate quad of given size.
    task automatic random_quad(int span);
        int ox, oy;
        ox = int'($urandom_range(0, 2 * span)) - span;
        oy = int'($urandom_range(0, 2 * span)) - span;
        quad[REG_C0X] = CW'(ox);
        quad[REG_C0Y] = CW'(oy);
        quad[REG_C1X] = CW'(ox + span + int'($urandom_range(0, span / 2)) - span / 4);
        quad[REG_C1Y] = CW'(oy + int'($urandom_range(0, span / 2)) - span / 4);
        quad[REG_C2X] = CW'(ox + span + int'($urandom_range(0, span / 2)) - span / 4);
        quad[REG_C2Y] = CW'(oy + span + int'($urandom_range(0, span / 2)) - span / 4);
        quad[REG_C3X] = CW'(ox + int'($urandom_range(0, span / 2)) - span / 4);
        quad[REG_C3Y] = CW'(oy + span + int'($urandom_range(0, span / 2)) - span / 4);
        // parallelogram now and then so the linear case is reached
        if ($urandom_range(0, 3) == 0)
        begin
            quad[REG_C2X] = quad[REG_C1X] + quad[REG_C3X] - quad[REG_C0X];
            quad[REG_C2Y] = quad[REG_C1Y] + quad[REG_C3Y] - quad[REG_C0Y];
        end
    endtask

    initial
    begin
        logic signed [CW-1:0] px, py;
        int span, sent, burst;
        logic signed [CW-1:0] cmax, cmin;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        for (int i = 0; i < NREG; i++)
            quad[i] = CFG_RST[i];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit square at reset values.
        send_point(128, 128);       // center
        send_point(1, 1);           // tiny u, v
        send_point(255, 255);       // just below one
        send_point(0, 128);         // on the edge
        send_point(256, 128);       // on the far edge
        send_point(-5, 300);        // outside
        send_point(cmax, cmax);     // field extremes
        send_point(cmin, cmin);
        send_point(cmax, cmin);
        send_point(-1, -1);
        drain();

        // Trapezoid: quadratic case, both root orders.
        quad = '{0, 0, 1024, 0, 768, 512, 256, 512};
        load_quad();
        send_point(512, 256);
        send_point(100, 10);
        send_point(900, 20);
        send_point(512, 600);
        send_point(512, -600);      // negative discriminant region likely
        drain();

        // Collapsed quad: all corners equal, every divisor zero.
        quad = '{77, 77, 77, 77, 77, 77, 77, 77};
        load_quad();
        send_point(77, 77);
        send_point(80, 70);
        drain();

        // Extreme corners, full coordinate span.
        quad = '{cmin, cmin, cmax, cmin, cmax, cmax, cmin, cmax};
        load_quad();
        send_point(0, 0);
        send_point(cmax, cmax);
        send_point(cmin + 1, cmin + 1);
        send_point(-4096, 4096);
        drain();

        // Bow-tie: self-crossing quad.
        quad = '{0, 0, 512, 512, 512, 0, 0, 512};
        load_quad();
        send_point(256, 100);
        send_point(100, 256);
        drain();

        // Random phases with bursts and gaps; mostly small quads.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            span = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1 << 16, 1 << 21))
                                               : int'($urandom_range(4, 2048));
            random_quad(span);
            load_quad();
            for (int n = 0; n < 100 && sent < N_RANDOM; )
            begin
                burst = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(1, 8));
                for (int b = 0; b < burst && n < 100; b++)
                begin
                    random_point(span, px, py);
                    send_point(px, py);
                    n++;
                    sent++;
                end
                idle_gap($urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 6)));
            end
            drain();
        end

        // a result still owed counts against the run
        if (fail_count == 0 && pending == 0)
            $display("tb_inverse_bilinear_quad_map_top: done, clean");
        else
            $display("tb_inverse_bilinear_quad_map_top: done, errors");
        $finish;
    end

endmodule
